// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver: status codes and
// the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DISC_W   = 34;
  localparam int unsigned ROOT_W   = 25;

  typedef enum logic [STATUS_W-1:0] {
    ST_NO_ROOT   = 2'd0,
    ST_DOUBLE    = 2'd1,
    ST_TWO_ROOTS = 2'd2,
    ST_LEAD_ZERO = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed Q8.8, with the Q16.16 discriminant
// and a status code. Fully pipelined: multiply, discriminant, one square
// root bit per stage, then two restoring dividers at one quotient bit a stage.
// Throughput: one request per cycle while the output is not stalled; a stalled output lets bubbles fill up.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic signed [DISC_W-1:0]     discriminant_o,
  output logic signed [ROOT_W-1:0]     root_plus_o,
  output logic signed [ROOT_W-1:0]     root_minus_o
);

  localparam int unsigned W  = COEF_WIDTH;
  localparam int unsigned DW = 2 * W + 2;   // discriminant
  localparam int unsigned SW = W + 1;       // square root
  localparam int unsigned RS = DW + 1;      // square root remainder
  localparam int unsigned NW = W + 9;       // scaled numerator magnitude
  localparam int unsigned NS = 5 + SW + NW; // pipeline stages

  localparam int unsigned ST_NUM = 3 + SW;
  localparam int unsigned ST_OUT = 4 + SW + NW;

  typedef struct packed {
    status_e               status;
    logic signed [DW-1:0]  disc;
    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    logic [RS-1:0]         rem;
    logic [SW-1:0]         root;
  } sq_t;

  typedef struct packed {
    status_e               status;
    logic signed [DW-1:0]  disc;
    logic                  neg_p;
    logic                  neg_m;
    logic [W:0]            dmag;
    logic [NW-1:0]         num_p;
    logic [NW-1:0]         num_m;
    logic [W:0]            rem_p;
    logic [W:0]            rem_m;
    logic [NW-1:0]         quo_p;
    logic [NW-1:0]         quo_m;
  } div_t;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = ~v_q[NS-1] | ~stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign stall_o = ~en[0];
  assign valid_o = v_q[NS-1];

  // Move valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // Stage 0: capture the request
  logic signed [W-1:0] s0_a_q, s0_b_q, s0_c_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_a_q <= coef_a_i;
      s0_b_q <= coef_b_i;
      s0_c_q <= coef_c_i;
    end
  end

  // Stage 1: products b*b and a*c
  logic signed [2*W-1:0] s1_bb_q, s1_ac_q;
  logic signed [W-1:0]   s1_a_q, s1_b_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_bb_q <= s0_b_q * s0_b_q;
      s1_ac_q <= s0_a_q * s0_c_q;
      s1_a_q  <= s0_a_q;
      s1_b_q  <= s0_b_q;
    end
  end

  // Stage 2: discriminant and classification
  logic signed [DW-1:0] s2_disc;
  status_e              s2_status;

  always_comb begin
    s2_disc = DW'(s1_bb_q) - (DW'(s1_ac_q) <<< 2);
    if (s1_a_q == '0) begin
      s2_status = ST_LEAD_ZERO;
    end else if (s2_disc < 0) begin
      s2_status = ST_NO_ROOT;
    end else if (s2_disc == '0) begin
      s2_status = ST_DOUBLE;
    end else begin
      s2_status = ST_TWO_ROOTS;
    end
  end

  sq_t sq_q [SW+1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_q[0].status <= s2_status;
      sq_q[0].disc   <= s2_disc;
      sq_q[0].a      <= s1_a_q;
      sq_q[0].b      <= s1_b_q;
      sq_q[0].rem    <= (s2_disc > 0) ? RS'(unsigned'(s2_disc)) : '0;
      sq_q[0].root   <= '0;
    end
  end

  // Square root: one result bit per stage, most significant first
  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    localparam int unsigned I = SW - 1 - j;
    logic [RS-1:0] trial;
    sq_t           nxt;

    always_comb begin
      nxt   = sq_q[j];
      trial = (RS'(sq_q[j].root) << (I + 1)) + (RS'(1) << (2 * I));
      if (sq_q[j].rem >= trial) begin
        nxt.rem     = sq_q[j].rem - trial;
        nxt.root[I] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[3+j]) begin
        sq_q[j+1] <= nxt;
      end
    end
  end

  // Numerator stage: -b +/- root, split into magnitude and sign
  logic signed [W+2:0] nb, n_p, n_m;
  logic [W+2:0]        mag_p, mag_m;
  logic [W:0]          a2;
  div_t                num_d;
  div_t                div_q [NW+1];

  always_comb begin
    nb    = -(W+3)'(sq_q[SW].b);
    n_p   = nb + signed'({2'b00, sq_q[SW].root});
    n_m   = nb - signed'({2'b00, sq_q[SW].root});
    mag_p = n_p[W+2] ? unsigned'(-n_p) : unsigned'(n_p);
    mag_m = n_m[W+2] ? unsigned'(-n_m) : unsigned'(n_m);
    a2    = {sq_q[SW].a, 1'b0};

    num_d        = '0;
    num_d.status = sq_q[SW].status;
    num_d.disc   = sq_q[SW].disc;
    num_d.neg_p  = n_p[W+2] ^ sq_q[SW].a[W-1];
    num_d.neg_m  = n_m[W+2] ^ sq_q[SW].a[W-1];
    num_d.dmag   = sq_q[SW].a[W-1] ? (-a2) : a2;
    num_d.num_p  = {mag_p[W:0], 8'b0};
    num_d.num_m  = {mag_m[W:0], 8'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_NUM]) begin
      div_q[0] <= num_d;
    end
  end

  // Dividers: one quotient bit per stage for each root
  for (genvar k = 0; k < NW; k++) begin : g_div
    localparam int unsigned B = NW - 1 - k;
    logic [W+1:0] r_p, r_m;
    div_t         nxt;

    always_comb begin
      nxt = div_q[k];
      r_p = {div_q[k].rem_p, div_q[k].num_p[B]};
      r_m = {div_q[k].rem_m, div_q[k].num_m[B]};
      if (r_p >= {1'b0, div_q[k].dmag}) begin
        nxt.rem_p = (W+1)'(r_p - {1'b0, div_q[k].dmag});
        nxt.quo_p = {div_q[k].quo_p[NW-2:0], 1'b1};
      end else begin
        nxt.rem_p = (W+1)'(r_p);
        nxt.quo_p = {div_q[k].quo_p[NW-2:0], 1'b0};
      end
      if (r_m >= {1'b0, div_q[k].dmag}) begin
        nxt.rem_m = (W+1)'(r_m - {1'b0, div_q[k].dmag});
        nxt.quo_m = {div_q[k].quo_m[NW-2:0], 1'b1};
      end else begin
        nxt.rem_m = (W+1)'(r_m);
        nxt.quo_m = {div_q[k].quo_m[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_NUM+1+k]) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // Output stage: apply signs, drop roots that do not exist, clear the discriminant for a zero leading coefficient
  logic signed [NW:0] q_p, q_m;
  status_e            out_status_q;
  logic signed [DISC_W-1:0] out_disc_q;
  logic signed [ROOT_W-1:0] out_rp_q, out_rm_q;

  always_comb begin
    q_p = div_q[NW].neg_p ? -signed'({1'b0, div_q[NW].quo_p}) : signed'({1'b0, div_q[NW].quo_p});
    q_m = div_q[NW].neg_m ? -signed'({1'b0, div_q[NW].quo_m}) : signed'({1'b0, div_q[NW].quo_m});
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_status_q <= div_q[NW].status;
      case (div_q[NW].status)
        ST_LEAD_ZERO: begin
          out_disc_q <= '0;
          out_rp_q   <= '0;
          out_rm_q   <= '0;
        end
        ST_NO_ROOT: begin
          out_disc_q <= DISC_W'(div_q[NW].disc);
          out_rp_q   <= '0;
          out_rm_q   <= '0;
        end
        default: begin
          out_disc_q <= DISC_W'(div_q[NW].disc);
          out_rp_q   <= ROOT_W'(q_p);
          out_rm_q   <= ROOT_W'(q_m);
        end
      endcase
    end
  end

  assign status_o       = out_status_q;
  assign discriminant_o = out_disc_q;
  assign root_plus_o    = out_rp_q;
  assign root_minus_o   = out_rm_q;

  // Checks on the result
  a_double_same : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_DOUBLE) |-> root_plus_o == root_minus_o)
    else $error("double root differs between fields");

  a_no_root_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ((status_o == ST_NO_ROOT) || (status_o == ST_LEAD_ZERO))
    |-> (root_plus_o == '0) && (root_minus_o == '0))
    else $error("roots not cleared without real root");

  a_lead_zero_disc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ST_LEAD_ZERO) |-> discriminant_o == '0)
    else $error("discriminant not cleared for zero leading coefficient");

endmodule
